/* src/rmt_pkg.sv */
// Package for the ranked member table: transaction types, table entry type,
// command codes and the ranking compare. No dependencies.
package rmt_pkg;

    localparam logic CMD_UPSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] member_key;
        logic [15:0] member_weight;
        logic        member_active;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  rank_after;
        logic [63:0] head_key;
        logic [63:0] second_key;
        logic [4:0]  member_total;
        logic        order_changed;
        logic [31:0] change_seq;
        logic        table_full;
    } t_out_item;

    // Classified command handed from the front to the back.
    typedef struct packed {
        logic        is_remove;
        logic [63:0] key;
        logic [15:0] weight;
        logic        active;
    } t_op;

    typedef struct packed {
        logic        active;
        logic [15:0] weight;
        logic [63:0] key;
    } t_entry;

    // True when entry a ranks strictly above entry b.
    function automatic logic ranks_above(input t_entry a, input t_entry b);
        logic r;
        if (a.active != b.active) begin
            r = a.active;
        end else if (a.weight != b.weight) begin
            r = (a.weight > b.weight);
        end else begin
            r = (a.key < b.key);
        end
        return r;
    endfunction

endpackage

/* src/rmt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/rmt_front.sv */
// Front end of the ranked member table: two-entry command queue and command
// decode. Depends on rmt_pkg.
module rmt_front
    import rmt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_op_valid,
    input  logic     i_op_ready,
    output t_op      o_op
);
    t_in_item   r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;
    logic       w_push, w_pop;
    t_in_item   w_head;

    assign o_in_ready = (r_fill != 2'd2);
    assign o_op_valid = (r_fill != 2'd0);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_op_valid && i_op_ready;
    assign w_head     = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_in_item;
        end
    end

    always_comb begin
        o_op.key    = w_head.member_key;
        o_op.weight = w_head.member_weight;
        o_op.active = w_head.member_active;
        unique case (w_head.command)
            CMD_REMOVE: o_op.is_remove = 1'b1;
            default:    o_op.is_remove = 1'b0;
        endcase
    end
endmodule

/* src/rmt_back.sv */
// Back end of the ranked member table: sequencer that searches, shifts and
// places entries in the table RAM and forms the result. Depends on rmt_pkg
// and rmt_ram.
module rmt_back
    import rmt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_op_valid,
    output logic      o_op_ready,
    input  t_op       i_op,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_SCAN_RD  = 12'b000000000010,
        S_SCAN_CHK = 12'b000000000100,
        S_MISS     = 12'b000000001000,
        S_NEXT_RD  = 12'b000000010000,
        S_NEXT_CHK = 12'b000000100000,
        S_GAP_RD   = 12'b000001000000,
        S_GAP_WR   = 12'b000010000000,
        S_PLACE_RD = 12'b000100000000,
        S_PLACE_CHK= 12'b001000000000,
        S_HEAD_RD  = 12'b010000000000,
        S_SEC_RD   = 12'b100000000000
    } t_state;

    t_state    r_state, n_state;
    logic      r_sec_chk, n_sec_chk;
    logic      r_done, n_done;
    t_op       r_op, n_op;
    logic [CW-1:0] r_i, n_i, r_found, n_found, r_j, n_j, r_count, n_count, r_rank, n_rank;
    t_entry    r_prev, n_prev;
    logic      r_changed, n_changed, r_full, n_full;
    logic [31:0] r_seq, n_seq;
    logic [63:0] r_head, n_head, r_second, n_second;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_q;
    logic [EW-1:0] ram_q_bits;
    t_entry        w_new;
    logic [CW-1:0] w_i_inc, w_found_inc, w_j_inc, w_j_dec;
    logic          w_load;

    rmt_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q_bits)
    );

    assign ram_q       = t_entry'(ram_q_bits);
    assign w_new       = '{active: r_op.active, weight: r_op.weight, key: r_op.key};
    assign w_i_inc     = CW'(r_i + 1'b1);
    assign w_found_inc = CW'(r_found + 1'b1);
    assign w_j_inc     = CW'(r_j + 1'b1);
    assign w_j_dec     = CW'(r_j - 1'b1);
    assign w_load      = r_done && (!r_out_valid || i_out_ready);
    assign o_op_ready  = (r_state == S_IDLE) && !r_sec_chk && !r_done;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state = r_state;  n_sec_chk = 1'b0;  n_done = r_done;
        n_op = r_op;  n_i = r_i;  n_found = r_found;  n_j = r_j;
        n_count = r_count;  n_rank = r_rank;  n_prev = r_prev;
        n_changed = r_changed;  n_full = r_full;  n_seq = r_seq;
        n_head = r_head;  n_second = r_second;
        n_out_valid = r_out_valid;  n_out = r_out;
        ram_we = 1'b0;  ram_waddr = '0;  ram_wdata = w_new;  ram_raddr = '0;

        if (r_sec_chk) begin
            n_second = (r_count > CW'(1)) ? ram_q.key : 64'd0;
            n_done   = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid && o_op_ready) begin
                    n_op      = i_op;
                    n_changed = 1'b0;
                    n_full    = 1'b0;
                    n_rank    = '0;
                    n_i       = '0;
                    n_state   = (r_count == '0) ? S_MISS : S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                ram_raddr = r_i[IW-1:0];
                n_state   = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (ram_q.key == r_op.key) begin
                    n_found = r_i;
                    n_state = S_NEXT_RD;
                end else begin
                    n_prev  = ram_q;
                    n_i     = w_i_inc;
                    n_state = (w_i_inc == r_count) ? S_MISS : S_SCAN_RD;
                end
            end
            S_MISS: begin
                if (r_op.is_remove) begin
                    n_state = S_HEAD_RD;
                end else if (r_count == CW'(ENTRIES)) begin
                    n_full  = 1'b1;
                    n_state = S_HEAD_RD;
                end else begin
                    n_j       = r_count;
                    n_count   = CW'(r_count + 1'b1);
                    n_changed = 1'b1;
                    n_state   = S_PLACE_RD;
                end
            end
            S_NEXT_RD: begin
                ram_raddr = w_found_inc[IW-1:0];
                n_j       = r_found;
                n_state   = r_op.is_remove ? S_GAP_RD : S_NEXT_CHK;
            end
            S_NEXT_CHK: begin
                if ((r_found == '0 || ranks_above(r_prev, w_new)) &&
                    (w_found_inc == r_count || ranks_above(w_new, ram_q))) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_found[IW-1:0];
                    n_rank    = w_found_inc;
                    n_state   = S_HEAD_RD;
                end else begin
                    n_state = S_GAP_RD;
                end
            end
            S_GAP_RD: begin
                if (w_j_inc == r_count) begin
                    n_changed = 1'b1;
                    if (r_op.is_remove) begin
                        n_count = CW'(r_count - 1'b1);
                        n_state = S_HEAD_RD;
                    end else begin
                        n_j     = CW'(r_count - 1'b1);
                        n_state = S_PLACE_RD;
                    end
                end else begin
                    ram_raddr = w_j_inc[IW-1:0];
                    n_state   = S_GAP_WR;
                end
            end
            S_GAP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IW-1:0];
                ram_wdata = ram_q;
                n_j       = w_j_inc;
                n_state   = S_GAP_RD;
            end
            S_PLACE_RD: begin
                if (r_j == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    n_rank    = CW'(1);
                    n_state   = S_HEAD_RD;
                end else begin
                    ram_raddr = w_j_dec[IW-1:0];
                    n_state   = S_PLACE_CHK;
                end
            end
            S_PLACE_CHK: begin
                ram_we    = 1'b1;
                ram_waddr = r_j[IW-1:0];
                if (ranks_above(ram_q, w_new)) begin
                    n_rank  = w_j_inc;
                    n_state = S_HEAD_RD;
                end else begin
                    ram_wdata = ram_q;
                    n_j       = w_j_dec;
                    n_state   = S_PLACE_RD;
                end
            end
            S_HEAD_RD: begin
                ram_raddr = '0;
                n_state   = S_SEC_RD;
            end
            S_SEC_RD: begin
                n_head    = (r_count != '0) ? ram_q.key : 64'd0;
                ram_raddr = IW'(1);
                n_sec_chk = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_seq               = r_seq + {31'd0, r_changed};
            n_out.rank_after    = 5'(r_rank);
            n_out.head_key      = r_head;
            n_out.second_key    = r_second;
            n_out.member_total  = 5'(r_count);
            n_out.order_changed = r_changed;
            n_out.change_seq    = n_seq;
            n_out.table_full    = r_full;
            n_out_valid         = 1'b1;
            n_done              = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sec_chk   <= 1'b0;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sec_chk   <= n_sec_chk;
            r_done      <= n_done;
            r_count     <= n_count;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_i       <= n_i;
        r_found   <= n_found;
        r_j       <= n_j;
        r_rank    <= n_rank;
        r_prev    <= n_prev;
        r_changed <= n_changed;
        r_full    <= n_full;
        r_head    <= n_head;
        r_second  <= n_second;
        r_out     <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("member count exceeds table size");

    a_full_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_full) |-> !r_changed)
        else $error("dropped insert marked as a change");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_changed) |=> (r_seq == $past(r_seq) + 32'd1))
        else $error("change counter did not advance");

    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op_valid && o_op_ready) |=> (r_state == S_SCAN_RD || r_state == S_MISS))
        else $error("accepted command did not start a search");
endmodule

/* src/ranked_member_table.sv */
// Top level of the ranked member table: command front end and table back end.
// Depends on rmt_pkg, rmt_front, rmt_back and rmt_ram.
//
//  Channel   Valid        Ready        Payload       Direction
//  input     i_in_valid   o_in_ready   i_in_item     into the block
//  output    o_out_valid  i_out_ready  o_out_item    out of the block
//
// Each transaction takes one pass of the table sequencer through the single
// read port of the table RAM: a search of up to N entries, a gap close of up
// to N entries, a placement of up to N entries, and a fetch of the two
// leading keys. A search, a gap close and a placement together never cover
// more than two passes over the table with N members present.
// Reset is synchronous and active low; it empties the table and clears the
// change counter at once, with no clearing pass.
// A two-entry queue takes new commands while the back end works, and the
// result register holds a finished result while the next command runs.
module ranked_member_table
    import rmt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    // Decoded commands flow from the queue to the sequencer.
    logic w_op_valid, w_op_ready;
    t_op  w_op;

    rmt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item (i_in_item),
        .o_op_valid(w_op_valid),
        .i_op_ready(w_op_ready),
        .o_op      (w_op)
    );

    // The back end owns the table RAM, the member count and the counter.
    rmt_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_op_valid),
        .o_op_ready (w_op_ready),
        .i_op       (w_op),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );
endmodule
